/* design/u8dec_pkg.sv */
// Shared types and constants for the UTF-8 to code point decoder.
// Used by the front, queue, back and top-level modules.
`default_nettype none

package u8dec_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int LEN_W  = 3;
   localparam int REM_W  = 2;

   // Lead byte class patterns and payload masks.
   localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD2_DATA  = 8'h1F;
   localparam logic [BYTE_W-1:0] LEAD3_DATA  = 8'h0F;
   localparam logic [BYTE_W-1:0] LEAD4_DATA  = 8'h07;
   localparam logic [BYTE_W-1:0] CONT_DATA   = 8'h3F;

   localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
   localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

   typedef enum logic [2:0] {
      KIND_END,
      KIND_ASCII,
      KIND_LEAD2,
      KIND_LEAD3,
      KIND_LEAD4,
      KIND_OTHER
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
   } item_type;

endpackage

`default_nettype wire

/* design/u8dec_front.sv */
// Front end: classifies each incoming byte by its lead-byte pattern.
// Depends on u8dec_pkg for the item type and class constants.
`default_nettype none

module u8dec_front
   import u8dec_pkg::*;
(
   input  wire logic [BYTE_W-1:0] req_text_byte,
   output item_type               item
);

   kind_type kind;

   always_comb begin
      if (req_text_byte == '0) begin
         kind = KIND_END;
      end else if (req_text_byte < ASCII_LIMIT) begin
         kind = KIND_ASCII;
      end else if ((req_text_byte & LEAD2_MASK) == LEAD2_CODE) begin
         kind = KIND_LEAD2;
      end else if ((req_text_byte & LEAD3_MASK) == LEAD3_CODE) begin
         kind = KIND_LEAD3;
      end else if ((req_text_byte & LEAD4_MASK) == LEAD4_CODE) begin
         kind = KIND_LEAD4;
      end else begin
         kind = KIND_OTHER;
      end
   end

   assign item.kind = kind;
   assign item.data = req_text_byte;

endmodule

`default_nettype wire

/* design/u8dec_queue.sv */
// Small FIFO of classified bytes between the front and back ends.
// Depends on u8dec_pkg for the item type.
`default_nettype none

module u8dec_queue
   import u8dec_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output item_type      head_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("queue count above depth");

endmodule

`default_nettype wire

/* design/u8dec_back.sv */
// Back end: gathers payload bits of each sequence and registers results.
// Depends on u8dec_pkg for the item type, masks and lengths.
`default_nettype none

module u8dec_back
   import u8dec_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire item_type          item,
   output logic                   item_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CP_W-1:0]        rsp_code_point,
   output logic [LEN_W-1:0]       rsp_sequence_length
);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CP_W-1:0]  part_ff, part_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             out_valid_ff, out_valid_in;
   logic [CP_W-1:0]  out_cp_ff, out_cp_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;
   logic             emit;
   logic [CP_W-1:0]  shifted;

   // Advance only when the output register is free or draining this cycle.
   assign item_pop = item_valid && (!out_valid_ff || !rsp_stall);
   assign shifted  = {part_ff[CP_W-7:0], item.data[5:0] & CONT_DATA[5:0]};

   always_comb begin
      rem_in     = rem_ff;
      part_in    = part_ff;
      len_in     = len_ff;
      emit       = 1'b0;
      out_cp_in  = out_cp_ff;
      out_len_in = out_len_ff;
      if (item_pop) begin
         if (item.kind == KIND_END) begin
            rem_in  = '0;
            part_in = '0;
            len_in  = '0;
         end else if (rem_ff != '0) begin
            // Any nonzero byte counts as a continuation.
            if (rem_ff == REM_W'(1)) begin
               emit       = 1'b1;
               out_cp_in  = shifted;
               out_len_in = len_ff;
               rem_in     = '0;
               part_in    = '0;
               len_in     = '0;
            end else begin
               rem_in  = rem_ff - REM_W'(1);
               part_in = shifted;
            end
         end else begin
            case (item.kind)
               KIND_ASCII: begin
                  emit       = 1'b1;
                  out_cp_in  = CP_W'(item.data);
                  out_len_in = LEN_1;
               end
               KIND_LEAD2: begin
                  part_in = CP_W'(item.data & LEAD2_DATA);
                  rem_in  = REM_W'(1);
                  len_in  = LEN_2;
               end
               KIND_LEAD3: begin
                  part_in = CP_W'(item.data & LEAD3_DATA);
                  rem_in  = REM_W'(2);
                  len_in  = LEN_3;
               end
               KIND_LEAD4: begin
                  part_in = CP_W'(item.data & LEAD4_DATA);
                  rem_in  = REM_W'(3);
                  len_in  = LEN_4;
               end
               default: begin
                  // drop invalid lead
               end
            endcase
         end
      end
      out_valid_in = emit || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         part_ff      <= '0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         part_ff      <= part_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_cp_ff  <= out_cp_in;
      out_len_ff <= out_len_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_code_point      = out_cp_ff;
   assign rsp_sequence_length = out_len_ff;

   // The length stays fixed while the remaining count runs down, so it exceeds that count and is at most four.
   a_len_tracks_rem: assert property (@(posedge clock) disable iff (reset)
      rem_ff != '0 |-> len_ff > LEN_W'(rem_ff) && len_ff <= LEN_4)
      else $error("pending length out of step with remaining count");

   a_ascii_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_len_ff == LEN_1 |-> out_cp_ff < CP_W'(ASCII_LIMIT))
      else $error("single-byte result above ASCII range");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      item_pop && item.kind == KIND_END |=> rem_ff == '0 && part_ff == '0)
      else $error("end of text did not clear the pending sequence");

endmodule

`default_nettype wire

/* design/utf8_to_codepoint_decoder.sv */
// UTF-8 byte stream to code point decoder, top level.
// A byte that completes a sequence is stored in a queue slot, then its result is held in the output register.
// Throughput: one byte per cycle while rsp_stall is low, as the classify and shift are combinational.
// Back pressure reaches req_stall once the QUEUE_DEPTH-entry queue fills.
// Synchronous reset empties the queue and output register and drops any partial sequence.
`default_nettype none

module utf8_to_codepoint_decoder
   import u8dec_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_text_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CP_W-1:0]        rsp_code_point,
   output logic [LEN_W-1:0]       rsp_sequence_length
);

   item_type front_item;
   item_type head_item;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;

   u8dec_front u_front (
      .req_text_byte (req_text_byte),
      .item          (front_item)
   );

   u8dec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   u8dec_back u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (q_not_empty),
      .item                (head_item),
      .item_pop            (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_code_point      (rsp_code_point),
      .rsp_sequence_length (rsp_sequence_length)
   );

   assign req_stall = q_full;

endmodule

`default_nettype wire
